### hdl/polled_uart_transmitter_top_macros.svh
// Assertion macros used by the checker file of the polled UART transmitter.
`ifndef POLLED_UART_TRANSMITTER_TOP_MACROS_SVH
`define POLLED_UART_TRANSMITTER_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PUT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define PUT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/put_pkg.sv
// Types and constants of the polled UART transmitter.
package put_pkg;

   localparam int CHANNELS   = 2;
   localparam int DATA_WIDTH = 8;
   localparam int STOP_COUNT = 1;

   typedef logic [3:0] phase_type;

   localparam phase_type PH_IDLE       = 4'd0;
   localparam phase_type PH_START      = 4'd1;
   localparam phase_type PH_LAST_DATA  = phase_type'(1 + DATA_WIDTH);
   localparam phase_type PH_FIRST_STOP = phase_type'(2 + DATA_WIDTH);
   localparam phase_type PH_END        = phase_type'(1 + DATA_WIDTH + STOP_COUNT);

   localparam logic OP_POLL = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [7:0] BIT_PERIOD_RESET = 8'd104;

endpackage

### hdl/polled_uart_transmitter_top.sv
// Top level of the polled multi-channel UART transmitter.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  operation, channel, data_byte, time_now
//   rsp      out        rsp_valid/rsp_ready  line_level, line_driven, data_waiting, busy_res
//   csr      in         csr_valid/csr_ready  bit_period
//
// Each request passes through the input register and then the result register.
// A new request is taken every cycle while results drain.
// The channel state is updated as a request leaves the input register, so requests to
// the same channel back to back see each other's effects in order.
// Synchronous reset clears the control state, idles both lines and sets bit_period to 104.
// A stalled result holds the pipeline; requests are refused only once both stages are full.
module polled_uart_transmitter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic       req_channel,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_time_now,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_line_level,
   output logic       rsp_line_driven,
   output logic       rsp_data_waiting,
   output logic       rsp_busy_res,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_bit_period
);

   logic       in_valid_ff;
   logic       in_op_ff;
   logic       in_ch_ff;
   logic [7:0] in_byte_ff;
   logic [7:0] in_time_ff;

   logic [7:0] bit_period_ff;

   put_pkg::phase_type phase_ff     [put_pkg::CHANNELS];
   logic [7:0]         shift_ff     [put_pkg::CHANNELS];
   logic [7:0]         last_ff      [put_pkg::CHANNELS];
   logic [7:0]         pend_byte_ff [put_pkg::CHANNELS];
   logic               pend_flag_ff [put_pkg::CHANNELS];
   logic               line_ff      [put_pkg::CHANNELS];

   put_pkg::phase_type phase_in;
   logic [7:0]         shift_in;
   logic [7:0]         last_in;
   logic               pend_flag_in;
   logic               line_in;
   logic               driven_in;
   logic [7:0]         elapsed;

   logic rsp_valid_ff;
   logic rsp_line_level_ff;
   logic rsp_line_driven_ff;
   logic rsp_data_waiting_ff;
   logic rsp_busy_res_ff;

   logic advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_level   = rsp_line_level_ff;
   assign rsp_line_driven  = rsp_line_driven_ff;
   assign rsp_data_waiting = rsp_data_waiting_ff;
   assign rsp_busy_res     = rsp_busy_res_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_op_ff   <= req_operation;
         in_ch_ff   <= req_channel;
         in_byte_ff <= req_data_byte;
         in_time_ff <= req_time_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= put_pkg::BIT_PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         bit_period_ff <= csr_bit_period;
      end
   end

   assign elapsed = in_time_ff - last_ff[in_ch_ff];

   // Next state of the addressed channel.
   always_comb begin
      phase_in     = phase_ff[in_ch_ff];
      shift_in     = shift_ff[in_ch_ff];
      last_in      = last_ff[in_ch_ff];
      pend_flag_in = pend_flag_ff[in_ch_ff];
      line_in      = line_ff[in_ch_ff];
      driven_in    = 1'b0;
      if (in_op_ff == put_pkg::OP_LOAD) begin
         pend_flag_in = 1'b1;
      end else if (phase_ff[in_ch_ff] == put_pkg::PH_IDLE) begin
         if (pend_flag_ff[in_ch_ff]) begin
            shift_in     = pend_byte_ff[in_ch_ff];
            pend_flag_in = 1'b0;
            phase_in     = put_pkg::PH_START;
            last_in      = in_time_ff;
            line_in      = 1'b0;
            driven_in    = 1'b1;
         end
      end else if (elapsed >= bit_period_ff) begin
         // The reference moves by exactly one period so timing error does not build up.
         last_in = last_ff[in_ch_ff] + bit_period_ff;
         if (phase_ff[in_ch_ff] < put_pkg::PH_LAST_DATA) begin
            phase_in  = phase_ff[in_ch_ff] + 4'd1;
            line_in   = shift_ff[in_ch_ff][0];
            shift_in  = shift_ff[in_ch_ff] >> 1;
            driven_in = 1'b1;
         end else if (phase_ff[in_ch_ff] == put_pkg::PH_LAST_DATA) begin
            phase_in  = put_pkg::PH_FIRST_STOP;
            line_in   = 1'b1;
            driven_in = 1'b1;
         end else if (phase_ff[in_ch_ff] >= put_pkg::PH_END) begin
            phase_in = put_pkg::PH_IDLE;
         end else begin
            phase_in = phase_ff[in_ch_ff] + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < put_pkg::CHANNELS; c++) begin
            phase_ff[c]     <= put_pkg::PH_IDLE;
            shift_ff[c]     <= 8'd0;
            last_ff[c]      <= 8'd0;
            pend_flag_ff[c] <= 1'b0;
            line_ff[c]      <= 1'b1;
         end
      end else if (advance) begin
         phase_ff[in_ch_ff]     <= phase_in;
         shift_ff[in_ch_ff]     <= shift_in;
         last_ff[in_ch_ff]      <= last_in;
         pend_flag_ff[in_ch_ff] <= pend_flag_in;
         line_ff[in_ch_ff]      <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_op_ff == put_pkg::OP_LOAD) begin
         pend_byte_ff[in_ch_ff] <= in_byte_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_line_level_ff   <= line_in;
         rsp_line_driven_ff  <= driven_in;
         rsp_data_waiting_ff <= pend_flag_in;
         rsp_busy_res_ff     <= (phase_in != put_pkg::PH_IDLE);
      end
   end

endmodule

### hdl/put_checker.sv
// Port checker for the polled UART transmitter and its bind to the top level.
`include "polled_uart_transmitter_top_macros.svh"

module put_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_line_level,
   input logic rsp_line_driven,
   input logic rsp_data_waiting,
   input logic rsp_busy_res
);

   logic [3:0] rsp_bits;

   assign rsp_bits = {rsp_line_level, rsp_line_driven, rsp_data_waiting, rsp_busy_res};

   // No result can be waiting in the cycle after reset.
   `PUT_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // A stalled result must not change or vanish before its transfer.
   `PUT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bits), "stalled result changed")

   // Start, data and first stop bits are driven only inside a frame.
   `PUT_ASSERT(a_driven_busy, clock, reset, rsp_valid && rsp_line_driven |-> rsp_busy_res, "line driven while idle")

   // The line returns high before the channel goes idle.
   `PUT_ASSERT(a_low_busy, clock, reset, rsp_valid && !rsp_line_level |-> rsp_busy_res, "line low while idle")

endmodule

bind polled_uart_transmitter_top put_checker u_put_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_line_level   (rsp_line_level),
   .rsp_line_driven  (rsp_line_driven),
   .rsp_data_waiting (rsp_data_waiting),
   .rsp_busy_res     (rsp_busy_res)
);

### test/polled_uart_transmitter_top_test.sv
// Self-checking testbench for the polled UART transmitter, with a line-state scoreboard.
module polled_uart_transmitter_top_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 106;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 80;
   localparam int CALM_FROM   = 450;
   localparam int CALM_TO     = 600;

   typedef struct packed {
      logic level;
      logic driven;
      logic waiting;
      logic busy;
   } line_status_type;

   // Tracks every channel's frame and predicts the line status each transfer reports.
   class line_state_board;
      logic [7:0]         period;
      put_pkg::phase_type phase     [put_pkg::CHANNELS];
      logic [7:0]         shifter   [put_pkg::CHANNELS];
      logic [7:0]         last_time [put_pkg::CHANNELS];
      logic [7:0]         held_byte [put_pkg::CHANNELS];
      logic               held      [put_pkg::CHANNELS];
      logic               line      [put_pkg::CHANNELS];
      line_status_type    expected_line_states [$];
      int                 mismatches;
      int                 results_seen;

      function new();
         period = put_pkg::BIT_PERIOD_RESET;
         for (int c = 0; c < put_pkg::CHANNELS; c++) begin
            phase[c]     = put_pkg::PH_IDLE;
            shifter[c]   = 8'h00;
            last_time[c] = 8'h00;
            held_byte[c] = 8'h00;
            held[c]      = 1'b0;
            line[c]      = 1'b1;
         end
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function int pending();
         return expected_line_states.size();
      endfunction

      function void note_request(logic op, logic ch, logic [7:0] data, logic [7:0] now);
         line_status_type    st;
         logic [7:0]         elapsed;
         put_pkg::phase_type ph;
         st.driven = 1'b0;
         ph = phase[ch];
         elapsed = now - last_time[ch];
         if (op == put_pkg::OP_LOAD) begin
            held_byte[ch] = data;
            held[ch] = 1'b1;
         end else if (ph == put_pkg::PH_IDLE) begin
            if (held[ch]) begin
               shifter[ch]   = held_byte[ch];
               held[ch]      = 1'b0;
               phase[ch]     = put_pkg::PH_START;
               last_time[ch] = now;
               line[ch]      = 1'b0;
               st.driven     = 1'b1;
            end
         end else if (elapsed >= period) begin
            // The reference moves by exactly one period, so late polls catch up.
            last_time[ch] = last_time[ch] + period;
            if (ph < put_pkg::PH_LAST_DATA) begin
               phase[ch]   = put_pkg::phase_type'(ph + 4'd1);
               line[ch]    = shifter[ch][0];
               shifter[ch] = shifter[ch] >> 1;
               st.driven   = 1'b1;
            end else if (ph == put_pkg::PH_LAST_DATA) begin
               phase[ch] = put_pkg::PH_FIRST_STOP;
               line[ch]  = 1'b1;
               st.driven = 1'b1;
            end else if (ph >= put_pkg::PH_END) begin
               phase[ch] = put_pkg::PH_IDLE;
            end else begin
               phase[ch] = put_pkg::phase_type'(ph + 4'd1);
            end
         end
         st.level   = line[ch];
         st.waiting = held[ch];
         st.busy    = (phase[ch] != put_pkg::PH_IDLE);
         expected_line_states.push_back(st);
      endfunction

      task report(string what);
         $display("result %0d: %s", results_seen, what);
         mismatches++;
      endtask

      task check_line_state(line_status_type got);
         line_status_type want;
         results_seen++;
         if (expected_line_states.size() == 0) begin
            report("result arrived with no request outstanding");
            return;
         end
         want = expected_line_states.pop_front();
         if (got.level !== want.level)
            report($sformatf("line_level %0b, predicted %0b", got.level, want.level));
         if (got.driven !== want.driven)
            report($sformatf("line_driven %0b, predicted %0b", got.driven, want.driven));
         if (got.waiting !== want.waiting)
            report($sformatf("data_waiting %0b, predicted %0b", got.waiting, want.waiting));
         if (got.busy !== want.busy)
            report($sformatf("busy_res %0b, predicted %0b", got.busy, want.busy));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_operation = put_pkg::OP_POLL;
   logic       req_channel = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic [7:0] req_time_now = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_line_level;
   logic       rsp_line_driven;
   logic       rsp_data_waiting;
   logic       rsp_busy_res;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_bit_period = put_pkg::BIT_PERIOD_RESET;

   line_state_board board = new();
   int          sent_count = 0;
   int          cycle_count = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   logic [7:0]  tick = 8'h00;
   logic [7:0]  phase_periods [8];
   wire         calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

   polled_uart_transmitter_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_channel      (req_channel),
      .req_data_byte    (req_data_byte),
      .req_time_now     (req_time_now),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_level   (rsp_line_level),
      .rsp_line_driven  (rsp_line_driven),
      .rsp_data_waiting (rsp_data_waiting),
      .rsp_busy_res     (rsp_busy_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bit_period   (csr_bit_period)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result side: random stalls, one long hold-off so the pipeline backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 9);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_line_state({rsp_line_level, rsp_line_driven, rsp_data_waiting,
                                 rsp_busy_res});
   end

   // Offers one request, after an occasional gap, and waits for its transfer.
   task automatic offer(input logic op, input logic ch, input logic [7:0] data,
                        input logic [7:0] now);
      while (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_channel   <= ch;
      req_data_byte <= data;
      req_time_now  <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(op, ch, data, now);
      sent_count <= sent_count + 1;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_period(input logic [7:0] value);
      csr_valid      <= 1'b1;
      csr_bit_period <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.period = value;
   endtask

   // Mostly polls on a tick that advances about half a period per request, so
   // frames run to completion; the rest is unrelated noise.
   task automatic random_item(input logic [7:0] period);
      logic       op;
      logic       ch;
      logic [7:0] data;
      logic [7:0] now;
      data = 8'($urandom);
      if ($urandom_range(99) < 80) begin
         op   = ($urandom_range(99) < 6) ? put_pkg::OP_LOAD : put_pkg::OP_POLL;
         ch   = 1'($urandom_range(1));
         tick = tick + 8'($urandom_range(period));
         now  = tick;
      end else begin
         op  = 1'($urandom);
         ch  = 1'($urandom);
         now = 8'($urandom);
      end
      offer(op, ch, data, now);
   endtask

   initial begin
      phase_periods = '{8'd1, 8'd128, 8'd255, 8'($urandom_range(1, 128)),
                        put_pkg::BIT_PERIOD_RESET, 8'($urandom_range(1, 128)), 8'd0,
                        8'($urandom_range(1, 128))};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Polling an idle channel with nothing waiting leaves it alone.
      offer(put_pkg::OP_POLL, 1'b0, 8'h00, 8'h00);
      offer(put_pkg::OP_LOAD, 1'b1, 8'h00, 8'hFF);
      // The second load replaces the byte that has not started yet.
      offer(put_pkg::OP_LOAD, 1'b1, 8'hFF, 8'h00);
      offer(put_pkg::OP_POLL, 1'b1, 8'h00, 8'd200);
      // Too early for the next bit.
      offer(put_pkg::OP_POLL, 1'b1, 8'hFF, 8'd250);
      for (int k = 1; k <= 10; k++)
         offer(put_pkg::OP_POLL, 1'b1, 8'h00, 8'(200 + 104 * k));
      wait_idle();

      // With a zero period every poll of a busy channel moves the frame on.
      write_period(8'd0);
      offer(put_pkg::OP_LOAD, 1'b0, 8'h5A, 8'h33);
      for (int k = 0; k < 7; k++)
         offer(put_pkg::OP_POLL, 1'b0, 8'h00, 8'h33);

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         write_period(phase_periods[p]);
         for (int i = 0; i < PHASE_ITEMS; i++)
            random_item(phase_periods[p]);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
